// ----- rtl/scba_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scba_pkg
// Shared types and constants of the size-class block allocator.
// ---------------------------------------------------------------------------
package scba_pkg;

    localparam int ADDR_W       = 22;
    localparam int SIZE_W       = 16;
    localparam int REGION_SHIFT = 19;
    localparam int IDX_W        = 16;
    localparam int BB_W         = 11;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_NULL_FREE = 3'd3,
        ST_BAD_FREE  = 3'd4
    } t_status;

    typedef struct packed {
        t_opcode             opcode;
        logic [SIZE_W-1:0]   request_size;
        logic [ADDR_W-1:0]   free_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   payload_address;
        t_status             status;
    } t_resp;

    // Result of decoding a freed address into class and block index.
    typedef struct packed {
        logic                bad;
        logic [2:0]          cls;
        logic [IDX_W-1:0]    idx;
    } t_free_dec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_CARVE,
        S_POP_RD,
        S_POP_WB,
        S_FREE_DEC,
        S_FREE_WB,
        S_RESP
    } t_state;

    // Payload bytes of a class: 8 << class.
    function automatic logic [BB_W-1:0] class_payload(input logic [2:0] c);
        class_payload = BB_W'(8) << c;
    endfunction

endpackage

// ----- rtl/scba_link_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scba_link_ram
// Single write, single read synchronous RAM holding {in_use, next_link}.
// ---------------------------------------------------------------------------
module scba_link_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 13
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/scba_free_dec.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scba_free_dec
// Three-stage decoder: freed address to class, block index and alignment,
// using a per-class reciprocal multiply and one correction step.
// ---------------------------------------------------------------------------
module scba_free_dec #(
    parameter int NUM_SIZE_CLASSES = 8,
    parameter int HEADER_BYTES     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [scba_pkg::ADDR_W-1:0]   i_addr,
    output logic                          o_valid,
    output scba_pkg::t_free_dec           o_dec
);

    localparam int RS    = 30;
    localparam int OFF_W = scba_pkg::REGION_SHIFT;
    localparam int RC_W  = 27;
    localparam int PR_W  = OFF_W + RC_W;
    localparam int QB_W  = scba_pkg::IDX_W + scba_pkg::BB_W;

    localparam logic [RC_W-1:0] RECIP [8] = '{
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 8)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 16)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 32)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 64)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 128)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 256)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 512)),
        RC_W'((64'd1 << RS) / (HEADER_BYTES + 1024))
    };

    logic                          r_v1, r_v2, r_v3;
    logic [2:0]                    r_cls1, r_cls2, r_cls3;
    logic [OFF_W-1:0]              r_off1, r_off2, r_off3;
    logic                          r_bad1, r_bad2, r_bad3;
    logic [PR_W-1:0]               r_prod;
    logic [scba_pkg::IDX_W-1:0]    r_q;
    logic [QB_W-1:0]               r_qbb;

    logic [2:0]                    cls0;
    logic [OFF_W-1:0]              local0;
    logic [scba_pkg::IDX_W-1:0]    q_est;
    logic [scba_pkg::BB_W-1:0]     bb1, bb2;
    logic [QB_W-1:0]               rem, rem_fix;
    logic                          ge;

    assign cls0   = i_addr[scba_pkg::ADDR_W-1:OFF_W];
    assign local0 = i_addr[OFF_W-1:0];
    assign q_est  = r_prod[RS +: scba_pkg::IDX_W];
    assign bb1    = scba_pkg::BB_W'(HEADER_BYTES) + scba_pkg::class_payload(r_cls2);
    assign bb2    = scba_pkg::BB_W'(HEADER_BYTES) + scba_pkg::class_payload(r_cls3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // Stage 1: split off class, strip the header.
        r_cls1 <= cls0;
        r_bad1 <= ({1'b0, cls0} >= 4'(NUM_SIZE_CLASSES)) ||
                  (local0 < OFF_W'(HEADER_BYTES));
        r_off1 <= local0 - OFF_W'(HEADER_BYTES);
        // Stage 2: scaled quotient estimate.
        r_cls2 <= r_cls1;
        r_bad2 <= r_bad1;
        r_off2 <= r_off1;
        r_prod <= PR_W'(r_off1) * PR_W'(RECIP[r_cls1]);
        // Stage 3: back-multiply the estimate.
        r_cls3 <= r_cls2;
        r_bad3 <= r_bad2;
        r_off3 <= r_off2;
        r_q    <= q_est;
        r_qbb  <= QB_W'(q_est) * QB_W'(bb1);
    end

    // Estimate is exact or one low; fix it with one compare and subtract.
    always_comb begin
        rem     = QB_W'(r_off3) - r_qbb;
        ge      = rem >= QB_W'(bb2);
        rem_fix = ge ? (rem - QB_W'(bb2)) : rem;
        o_dec.cls = r_cls3;
        o_dec.idx = ge ? (r_q + scba_pkg::IDX_W'(1)) : r_q;
        o_dec.bad = r_bad3 || (rem_fix != '0);
    end

    assign o_valid = r_v3;

endmodule

// ----- rtl/size_class_block_allocator.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list allocator: eight size classes, LIFO lists held in a
// link RAM, chunks carved on demand from per-class address regions.
// ---------------------------------------------------------------------------
// Sequence: an allocate goes from accept through the pop write-back to the
//   result when the list holds a block; when a chunk must be carved, it
//   first writes one link RAM entry per carved block, then reads the new
//   head. Free: 3-stage address decoder, one RAM read, one write-back.
//   Error results write nothing to the link RAM.
// Throughput: one transaction in flight; the next is accepted the cycle after
//   the result is loaded into the output register. Reset clears all list
//   heads and chunk counts at once; no clearing pass is needed.
module size_class_block_allocator #(
    parameter int NUM_SIZE_CLASSES = 8,
    parameter int BLOCKS_PER_CHUNK = 64,
    parameter int CHUNKS_PER_CLASS = 4,
    parameter int HEADER_BYTES     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  scba_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output scba_pkg::t_resp  o_resp
);

    localparam int BPCL     = BLOCKS_PER_CHUNK * CHUNKS_PER_CLASS;
    localparam int TOTAL    = NUM_SIZE_CLASSES * BPCL;
    localparam int BLK_W    = $clog2(TOTAL + 1);
    localparam int AW       = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int RAM_D    = 1 << AW;
    localparam int CLS_W    = (NUM_SIZE_CLASSES > 1) ? $clog2(NUM_SIZE_CLASSES) : 1;
    localparam int CARVED_W = $clog2(CHUNKS_PER_CLASS + 1);
    localparam int CNT_W    = (BLOCKS_PER_CHUNK > 1) ? $clog2(BLOCKS_PER_CHUNK) : 1;
    localparam int LIDX_W   = (BPCL > 1) ? $clog2(BPCL) : 1;
    localparam int OFS_W    = LIDX_W + scba_pkg::BB_W;
    localparam int LIM_W    = 17;
    localparam logic [BLK_W-1:0] EMPTY = BLK_W'(TOTAL);

    // Control state.
    scba_pkg::t_state        r_state, n_state;
    logic [BLK_W-1:0]        r_head   [NUM_SIZE_CLASSES];
    logic [CARVED_W-1:0]     r_carved [NUM_SIZE_CLASSES];
    logic [CNT_W-1:0]        r_carve_cnt;
    logic                    r_out_valid;

    // Transaction payload registers.
    scba_pkg::t_req          r_req;
    scba_pkg::t_resp         r_out;
    scba_pkg::t_status       r_status;
    logic [2:0]              r_cls;
    logic [BLK_W-1:0]        r_blk;
    logic [OFS_W-1:0]        r_addr_off;

    // Link RAM port.
    logic                    ram_wr_en, ram_rd_en;
    logic [AW-1:0]           ram_wr_addr, ram_rd_addr;
    logic [BLK_W:0]          ram_wr_data, ram_rd_data;
    logic                    rd_in_use;
    logic [BLK_W-1:0]        rd_link;

    // Decoder.
    logic                    dec_start, dec_valid;
    scba_pkg::t_free_dec     dec;

    logic                    accept, can_load, sel_hit, free_bad, carve_last;
    logic [2:0]              sel_cls;
    logic [BLK_W-1:0]        head_sel, head_cur, cls_base, dec_base;
    logic [BLK_W-1:0]        blk_carve, blk_free;
    logic [CARVED_W-1:0]     carved_sel, carved_cur;
    logic [LIM_W-1:0]        free_lim;
    logic [LIDX_W-1:0]       lidx;
    logic [scba_pkg::BB_W-1:0] bb_cur;

    assign accept     = i_valid && o_ready;
    assign can_load   = !r_out_valid || i_ready;
    assign rd_in_use  = ram_rd_data[BLK_W];
    assign rd_link    = ram_rd_data[BLK_W-1:0];
    assign carve_last = r_carve_cnt == CNT_W'(BLOCKS_PER_CHUNK - 1);

    // Smallest class whose payload holds the request; scan from the top down.
    always_comb begin
        sel_hit = 1'b0;
        sel_cls = '0;
        for (int k = NUM_SIZE_CLASSES - 1; k >= 0; k--) begin
            if (r_req.request_size <=
                scba_pkg::SIZE_W'(scba_pkg::class_payload(3'(k)))) begin
                sel_hit = 1'b1;
                sel_cls = 3'(k);
            end
        end
    end

    assign head_sel   = r_head[sel_cls[CLS_W-1:0]];
    assign carved_sel = r_carved[sel_cls[CLS_W-1:0]];
    assign head_cur   = r_head[r_cls[CLS_W-1:0]];
    assign carved_cur = r_carved[r_cls[CLS_W-1:0]];
    assign cls_base   = BLK_W'(r_cls) * BLK_W'(BPCL);
    assign dec_base   = BLK_W'(dec.cls) * BLK_W'(BPCL);
    assign blk_carve  = cls_base + BLK_W'(carved_cur) * BLK_W'(BLOCKS_PER_CHUNK)
                      + BLK_W'(r_carve_cnt);
    assign blk_free   = dec_base + BLK_W'(dec.idx);
    assign lidx       = LIDX_W'(r_blk - cls_base);
    assign bb_cur     = scba_pkg::BB_W'(HEADER_BYTES) + scba_pkg::class_payload(r_cls);

    // Reject a block index beyond what this class has carved so far.
    assign free_lim = LIM_W'(r_carved[dec.cls[CLS_W-1:0]]) * LIM_W'(BLOCKS_PER_CHUNK);
    assign free_bad = dec.bad || (LIM_W'(dec.idx) >= free_lim);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scba_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req.opcode == scba_pkg::OP_ALLOC) begin
                        n_state = scba_pkg::S_ALLOC;
                    end else if (i_req.free_address == '0) begin
                        n_state = scba_pkg::S_RESP;
                    end else begin
                        n_state = scba_pkg::S_FREE_DEC;
                    end
                end
            end
            scba_pkg::S_ALLOC: begin
                if (!sel_hit) begin
                    n_state = scba_pkg::S_RESP;
                end else if (head_sel != EMPTY) begin
                    n_state = scba_pkg::S_POP_WB;
                end else if (carved_sel == CARVED_W'(CHUNKS_PER_CLASS)) begin
                    n_state = scba_pkg::S_RESP;
                end else begin
                    n_state = scba_pkg::S_CARVE;
                end
            end
            scba_pkg::S_CARVE: begin
                if (carve_last) begin
                    n_state = scba_pkg::S_POP_RD;
                end
            end
            scba_pkg::S_POP_RD: n_state = scba_pkg::S_POP_WB;
            scba_pkg::S_POP_WB: n_state = scba_pkg::S_RESP;
            scba_pkg::S_FREE_DEC: begin
                if (dec_valid) begin
                    n_state = free_bad ? scba_pkg::S_RESP : scba_pkg::S_FREE_WB;
                end
            end
            scba_pkg::S_FREE_WB: n_state = scba_pkg::S_RESP;
            scba_pkg::S_RESP: begin
                if (can_load) begin
                    n_state = scba_pkg::S_IDLE;
                end
            end
            default: n_state = scba_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake, RAM port and decoder launch.
    always_comb begin
        o_ready     = r_state == scba_pkg::S_IDLE;
        dec_start   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        case (r_state)
            scba_pkg::S_IDLE: begin
                dec_start = accept && (i_req.opcode == scba_pkg::OP_FREE) &&
                            (i_req.free_address != '0);
            end
            scba_pkg::S_ALLOC: begin
                ram_rd_en   = sel_hit && (head_sel != EMPTY);
                ram_rd_addr = head_sel[AW-1:0];
            end
            scba_pkg::S_CARVE: begin
                // Push the carved block in front of the current head.
                ram_wr_en   = 1'b1;
                ram_wr_addr = blk_carve[AW-1:0];
                ram_wr_data = {1'b0, head_cur};
            end
            scba_pkg::S_POP_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = head_cur[AW-1:0];
            end
            scba_pkg::S_POP_WB: begin
                // Mark the popped block in use; keep its link.
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_blk[AW-1:0];
                ram_wr_data = {1'b1, rd_link};
            end
            scba_pkg::S_FREE_DEC: begin
                ram_rd_en   = dec_valid && !free_bad;
                ram_rd_addr = blk_free[AW-1:0];
            end
            scba_pkg::S_FREE_WB: begin
                ram_wr_en   = rd_in_use;
                ram_wr_addr = r_blk[AW-1:0];
                ram_wr_data = {1'b0, head_cur};
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scba_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_carve_cnt <= '0;
            for (int c = 0; c < NUM_SIZE_CLASSES; c++) begin
                r_head[c]   <= EMPTY;
                r_carved[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            // Load a fresh result, or drop the one just taken.
            if ((r_state == scba_pkg::S_RESP) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                scba_pkg::S_ALLOC: begin
                    r_carve_cnt <= '0;
                end
                scba_pkg::S_CARVE: begin
                    r_head[r_cls[CLS_W-1:0]] <= blk_carve;
                    r_carve_cnt <= r_carve_cnt + CNT_W'(1);
                    if (carve_last) begin
                        r_carved[r_cls[CLS_W-1:0]] <= carved_cur + CARVED_W'(1);
                    end
                end
                scba_pkg::S_POP_WB: begin
                    r_head[r_cls[CLS_W-1:0]] <= rd_link;
                end
                scba_pkg::S_FREE_WB: begin
                    if (rd_in_use) begin
                        r_head[r_cls[CLS_W-1:0]] <= r_blk;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            scba_pkg::S_IDLE: begin
                r_req    <= i_req;
                r_status <= scba_pkg::ST_NULL_FREE;
            end
            scba_pkg::S_ALLOC: begin
                r_cls <= sel_cls;
                r_blk <= head_sel;
                if (!sel_hit) begin
                    r_status <= scba_pkg::ST_TOO_LARGE;
                end else begin
                    r_status <= scba_pkg::ST_EXHAUSTED;
                end
            end
            scba_pkg::S_POP_RD: begin
                r_blk <= head_cur;
            end
            scba_pkg::S_POP_WB: begin
                r_addr_off <= OFS_W'(lidx) * OFS_W'(bb_cur);
                r_status   <= scba_pkg::ST_OK;
            end
            scba_pkg::S_FREE_DEC: begin
                r_cls    <= dec.cls;
                r_blk    <= blk_free;
                r_status <= scba_pkg::ST_BAD_FREE;
            end
            scba_pkg::S_FREE_WB: begin
                r_status <= rd_in_use ? scba_pkg::ST_OK : scba_pkg::ST_BAD_FREE;
            end
            scba_pkg::S_RESP: begin
                if (can_load) begin
                    r_out.status <= r_status;
                    if ((r_status == scba_pkg::ST_OK) &&
                        (r_req.opcode == scba_pkg::OP_ALLOC)) begin
                        r_out.payload_address <= {r_cls, scba_pkg::REGION_SHIFT'(0)}
                            + scba_pkg::ADDR_W'(r_addr_off)
                            + scba_pkg::ADDR_W'(HEADER_BYTES);
                    end else begin
                        r_out.payload_address <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_resp  = r_out;

    scba_link_ram #(
        .DEPTH (RAM_D),
        .WIDTH (BLK_W + 1)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    scba_free_dec #(
        .NUM_SIZE_CLASSES (NUM_SIZE_CLASSES),
        .HEADER_BYTES     (HEADER_BYTES)
    ) u_free_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dec_start),
        .i_addr  (i_req.free_address),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    // A pop always finds a real block: either the head was live or a chunk
    // was just carved.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scba_pkg::S_POP_WB) |-> (r_blk != EMPTY))
        else $error("pop from empty list");

    // Never carve past the class region.
    a_carve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scba_pkg::S_CARVE) |->
        (carved_cur < CARVED_W'(CHUNKS_PER_CLASS)))
        else $error("carve beyond region");

    // A free write-back only returns blocks that were handed out.
    a_free_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scba_pkg::S_FREE_WB && ram_wr_en) |-> rd_in_use)
        else $error("free of block not in use");

    // Failed or free results carry a zero address.
    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scba_pkg::S_RESP && can_load &&
         (r_status != scba_pkg::ST_OK || r_req.opcode == scba_pkg::OP_FREE))
        |=> (r_out.payload_address == '0))
        else $error("nonzero address on non-grant");

endmodule
